// ----- hw/rtl/first_fit_region_allocator_defines.svh -----
// Assertion macros shared by the first-fit region allocator RTL.
`ifndef FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define FFRA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("ffra assertion failed");
// Check that cond in one cycle implies res in the next.
`define FFRA_ASSERT_NEXT(lbl, clk, rstn, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (res)) \
    else $error("ffra assertion failed");
`else
`define FFRA_ASSERT(lbl, clk, rstn, prop)
`define FFRA_ASSERT_NEXT(lbl, clk, rstn, cond, res)
`endif

`endif

// ----- hw/rtl/ffra_pkg.sv -----
// Package with constants, codes and types of the first-fit region allocator.
`timescale 1ns / 1ps
package ffra_pkg;

  localparam int unsigned SLOTS      = 64;
  // Page size; must be a power of two.
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [32:0] PAGE_MASK  = 33'(PAGE_BYTES - 1);
  localparam logic [32:0] PAGE_SIZE  = 33'(PAGE_BYTES);

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_ALLOC_FULL = 3'd1,
    STAT_NO_SPACE   = 3'd2,
    STAT_NOT_FOUND  = 3'd3,
    STAT_FREE_FULL  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_A_SLOT,
    S_A_HOLE,
    S_A_COMMIT,
    S_F_FIND,
    S_F_MERGE,
    S_F_PLACE,
    S_DONE
  } state_e;

  localparam logic [0:0] REG_HEAP_BASE   = 1'b0;
  localparam logic [0:0] REG_HEAP_LENGTH = 1'b1;

  // Write port of a region table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [31:0]      start;
    logic [31:0]      length;
  } tbl_wr_t;

endpackage

// ----- hw/rtl/ffra_if.sv -----
// Valid/ready channel interfaces for allocator requests and responses.
`timescale 1ns / 1ps
interface ffra_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] request_size;
  logic [31:0] region_address;

  modport source (output valid, command, request_size, region_address, input ready);
  modport sink (input valid, command, request_size, region_address, output ready);
endinterface

interface ffra_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic [2:0]  status;

  modport source (output valid, granted_address, status, input ready);
  modport sink (input valid, granted_address, status, output ready);
endinterface

// ----- hw/rtl/ffra_table.sv -----
// Region table memory: start and length per slot, one write and one registered read port.
`timescale 1ns / 1ps
module ffra_table (
  input  logic                          clk_i,
  input  ffra_pkg::tbl_wr_t             wr_i,
  input  logic [ffra_pkg::IDX_W-1:0]    rd_addr_i,
  output logic [31:0]                   rd_start_o,
  output logic [31:0]                   rd_length_o
);

  logic [31:0] start_mem  [ffra_pkg::SLOTS];
  logic [31:0] length_mem [ffra_pkg::SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      start_mem[wr_i.addr]  <= wr_i.start;
      length_mem[wr_i.addr] <= wr_i.length;
    end
    rd_start_o  <= start_mem[rd_addr_i];
    rd_length_o <= length_mem[rd_addr_i];
  end

endmodule

// ----- hw/rtl/first_fit_region_allocator.sv -----
// Top level of the first-fit region allocator with free-region coalescing.
//
// Requests arrive on req (command, request_size, region_address) and each one
// yields exactly one response on rsp (granted_address, status). Commands:
// initialise the heap from heap_base/heap_length, allocate whole pages first
// fit, or free a region by its start address, merging it with every touching
// free region. Program heap_base and heap_length over the APB port while idle.
// One request is worked at a time; req.ready is high only while idle.
// Each table holds 64 slots. Allocate scans the used table for a free slot,
// then the hole table for the first hole that fits. Free scans the used
// table for the region, merges over the hole table in passes that repeat
// while merges keep happening, then scans for a free hole slot.
// The scans walk one table entry per cycle through the shared compare unit
// and the single read port of each table memory.
// Reset clears both valid vectors and the sequencer; no clearing pass runs.
// A finished response waits in an output register; if the receiver stalls a
// second response, the block holds it until the register drains.
`timescale 1ns / 1ps
`include "first_fit_region_allocator_defines.svh"
module first_fit_region_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffra_req_if.sink    req,
  ffra_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = ffra_pkg::IDX_W;
  localparam int unsigned CNT_W = ffra_pkg::CNT_W;

  // Configuration registers
  logic [31:0] heap_base_q, heap_length_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ffra_pkg::REG_HEAP_LENGTH) ? heap_length_q : heap_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q   <= '0;
      heap_length_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ffra_pkg::REG_HEAP_LENGTH) begin
        heap_length_q <= pwdata;
      end else begin
        heap_base_q <= pwdata;
      end
    end
  end

  // Sequencer and datapath state
  ffra_pkg::state_e  state_q, state_d;
  ffra_pkg::status_e res_status_q, res_status_d;
  ffra_pkg::status_e rsp_status_q, rsp_status_d;
  logic [31:0]       res_addr_q, res_addr_d;
  logic [31:0]       rsp_addr_q, rsp_addr_d;
  logic              rsp_vld_q, rsp_vld_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [31:0]       addr_q, addr_d;
  logic [32:0]       want_q, want_d;
  logic [31:0]       hstart_q, hstart_d;
  logic [31:0]       hlen_q, hlen_d;
  logic [32:0]       lo_q, lo_d, hi_q, hi_d;
  logic              changed_q, changed_d;
  logic              first_q, first_d;
  logic              empty_q, empty_d;
  logic [ffra_pkg::SLOTS-1:0] used_valid_q, used_valid_d;
  logic [ffra_pkg::SLOTS-1:0] hole_valid_q, hole_valid_d;

  // Table memories
  ffra_pkg::tbl_wr_t used_wr, hole_wr;
  logic [31:0] used_rd_start, used_rd_len, hole_rd_start, hole_rd_len;
  logic [IDX_W-1:0] idx;

  assign idx = cnt_q[IDX_W-1:0];

  ffra_table u_used (
    .clk_i       (clk_i),
    .wr_i        (used_wr),
    .rd_addr_i   (idx),
    .rd_start_o  (used_rd_start),
    .rd_length_o (used_rd_len)
  );

  ffra_table u_hole (
    .clk_i       (clk_i),
    .wr_i        (hole_wr),
    .rd_addr_i   (idx),
    .rd_start_o  (hole_rd_start),
    .rd_length_o (hole_rd_len)
  );

  // Shared compare unit: evaluates the entry read in the previous cycle
  logic        issue, scan_end, accept, out_free;
  logic        used_hit, hole_fit, hole_touch;
  logic        bit_empty_used, bit_empty_hole;
  logic [32:0] hole_s, hole_e, room, size_sum, size_round, want_in;
  logic [32:0] merge_len;
  logic [31:0] init_len, fit_len;

  assign issue    = cnt_q < ffra_pkg::SLOTS_CNT;
  assign scan_end = !issue && !rd_vld_q;
  assign accept   = req.valid && req.ready;
  assign out_free = !rsp_vld_q || rsp.ready;

  assign hole_s     = {1'b0, hole_rd_start};
  assign hole_e     = hole_s + {1'b0, hole_rd_len};
  assign used_hit   = rd_vld_q && used_valid_q[rd_idx_q] && (used_rd_start == addr_q);
  assign hole_fit   = rd_vld_q && hole_valid_q[rd_idx_q] && ({1'b0, hole_rd_len} >= want_q);
  assign hole_touch = rd_vld_q && hole_valid_q[rd_idx_q] && (hole_s <= hi_q) && (lo_q <= hole_e);
  assign bit_empty_used = issue && !used_valid_q[idx];
  assign bit_empty_hole = issue && !hole_valid_q[idx];

  // Round the request up to whole pages; zero takes one page
  assign size_sum   = {1'b0, req.request_size} + ffra_pkg::PAGE_MASK;
  assign size_round = size_sum & ~ffra_pkg::PAGE_MASK;
  assign want_in    = (req.request_size == '0) ? ffra_pkg::PAGE_SIZE : size_round;

  // Clip the heap so that it does not run past the top of the address space
  assign room     = 33'h1_0000_0000 - {1'b0, heap_base_q};
  assign init_len = ({1'b0, heap_length_q} > room) ? room[31:0] : heap_length_q;

  assign fit_len   = hlen_q - want_q[31:0];
  assign merge_len = hi_q - lo_q;

  assign req.ready           = (state_q == ffra_pkg::S_IDLE);
  assign rsp.valid           = rsp_vld_q;
  assign rsp.granted_address = rsp_addr_q;
  assign rsp.status          = rsp_status_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffra_pkg::S_IDLE: begin
        if (accept) begin
          unique case (ffra_pkg::cmd_e'(req.command))
            ffra_pkg::CMD_INIT:  state_d = ffra_pkg::S_INIT;
            ffra_pkg::CMD_ALLOC: state_d = ffra_pkg::S_A_SLOT;
            ffra_pkg::CMD_FREE:  state_d = ffra_pkg::S_F_FIND;
            default:             state_d = ffra_pkg::S_DONE;
          endcase
        end
      end
      ffra_pkg::S_INIT: state_d = ffra_pkg::S_DONE;
      ffra_pkg::S_A_SLOT: begin
        if (bit_empty_used) begin
          state_d = ffra_pkg::S_A_HOLE;
        end else if (!issue) begin
          state_d = ffra_pkg::S_DONE;
        end
      end
      ffra_pkg::S_A_HOLE: begin
        if (hole_fit) begin
          state_d = ffra_pkg::S_A_COMMIT;
        end else if (scan_end) begin
          state_d = ffra_pkg::S_DONE;
        end
      end
      ffra_pkg::S_A_COMMIT: state_d = ffra_pkg::S_DONE;
      ffra_pkg::S_F_FIND: begin
        if (used_hit) begin
          state_d = ffra_pkg::S_F_MERGE;
        end else if (scan_end) begin
          state_d = ffra_pkg::S_DONE;
        end
      end
      ffra_pkg::S_F_MERGE: begin
        if (scan_end && !changed_q) begin
          if (first_q && !empty_q) begin
            state_d = ffra_pkg::S_DONE;
          end else begin
            state_d = ffra_pkg::S_F_PLACE;
          end
        end
      end
      ffra_pkg::S_F_PLACE: begin
        if (bit_empty_hole || !issue) begin
          state_d = ffra_pkg::S_DONE;
        end
      end
      ffra_pkg::S_DONE: begin
        if (out_free) begin
          state_d = ffra_pkg::S_IDLE;
        end
      end
      default: state_d = ffra_pkg::S_IDLE;
    endcase
  end

  // Datapath and table updates
  always_comb begin
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    rsp_status_d = rsp_status_q;
    rsp_addr_d   = rsp_addr_q;
    rsp_vld_d    = rsp_vld_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = idx;
    slot_d       = slot_q;
    addr_d       = addr_q;
    want_d       = want_q;
    hstart_d     = hstart_q;
    hlen_d       = hlen_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    changed_d    = changed_q;
    first_d      = first_q;
    empty_d      = empty_q;
    used_valid_d = used_valid_q;
    hole_valid_d = hole_valid_q;
    used_wr      = '0;
    hole_wr      = '0;

    // Drop the response once taken
    if (rsp.valid && rsp.ready) begin
      rsp_vld_d = 1'b0;
    end

    unique case (state_q)
      ffra_pkg::S_IDLE: begin
        if (accept) begin
          addr_d       = req.region_address;
          want_d       = want_in;
          res_addr_d   = '0;
          res_status_d = ffra_pkg::STAT_OK;
          cnt_d        = '0;
        end
      end
      ffra_pkg::S_INIT: begin
        used_valid_d = '0;
        hole_valid_d = '0;
        if (init_len != '0) begin
          hole_wr.en      = 1'b1;
          hole_wr.addr    = '0;
          hole_wr.start   = heap_base_q;
          hole_wr.length  = init_len;
          hole_valid_d[0] = 1'b1;
        end
      end
      ffra_pkg::S_A_SLOT: begin
        if (bit_empty_used) begin
          slot_d = idx;
          cnt_d  = '0;
        end else if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          res_status_d = ffra_pkg::STAT_ALLOC_FULL;
        end
      end
      ffra_pkg::S_A_HOLE: begin
        if (hole_fit) begin
          rd_idx_d = rd_idx_q;
          hstart_d = hole_rd_start;
          hlen_d   = hole_rd_len;
        end else if (scan_end) begin
          res_status_d = ffra_pkg::STAT_NO_SPACE;
        end else if (issue) begin
          cnt_d    = cnt_q + 1'b1;
          rd_vld_d = 1'b1;
        end
      end
      ffra_pkg::S_A_COMMIT: begin
        // rd_idx_q still names the chosen hole
        hole_wr.en     = 1'b1;
        hole_wr.addr   = rd_idx_q;
        hole_wr.start  = hstart_q + want_q[31:0];
        hole_wr.length = fit_len;
        if (fit_len == '0) begin
          hole_valid_d[rd_idx_q] = 1'b0;
        end
        used_wr.en     = 1'b1;
        used_wr.addr   = slot_q;
        used_wr.start  = hstart_q;
        used_wr.length = want_q[31:0];
        used_valid_d[slot_q] = 1'b1;
        res_addr_d     = hstart_q;
      end
      ffra_pkg::S_F_FIND: begin
        if (used_hit) begin
          slot_d    = rd_idx_q;
          lo_d      = {1'b0, used_rd_start};
          hi_d      = {1'b0, used_rd_start} + {1'b0, used_rd_len};
          cnt_d     = '0;
          changed_d = 1'b0;
          first_d   = 1'b1;
          empty_d   = 1'b0;
        end else if (scan_end) begin
          res_status_d = ffra_pkg::STAT_NOT_FOUND;
        end else if (issue) begin
          cnt_d    = cnt_q + 1'b1;
          rd_vld_d = 1'b1;
        end
      end
      ffra_pkg::S_F_MERGE: begin
        if (rd_vld_q) begin
          if (hole_touch) begin
            if (hole_s < lo_q) lo_d = hole_s;
            if (hole_e > hi_q) hi_d = hole_e;
            hole_valid_d[rd_idx_q] = 1'b0;
            changed_d = 1'b1;
          end
          if (!hole_valid_q[rd_idx_q]) begin
            empty_d = 1'b1;
          end
        end
        if (issue) begin
          cnt_d    = cnt_q + 1'b1;
          rd_vld_d = 1'b1;
        end else if (scan_end) begin
          // Run another pass while merges keep happening
          cnt_d     = '0;
          changed_d = 1'b0;
          first_d   = 1'b0;
          if (!changed_q && first_q && !empty_q) begin
            res_status_d = ffra_pkg::STAT_FREE_FULL;
          end
        end
      end
      ffra_pkg::S_F_PLACE: begin
        if (bit_empty_hole) begin
          hole_wr.en     = 1'b1;
          hole_wr.addr   = idx;
          hole_wr.start  = lo_q[31:0];
          hole_wr.length = merge_len[32] ? 32'hFFFF_FFFF : merge_len[31:0];
          hole_valid_d[idx]    = 1'b1;
          used_valid_d[slot_q] = 1'b0;
        end else if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          used_valid_d[slot_q] = 1'b0;
        end
      end
      ffra_pkg::S_DONE: begin
        if (out_free) begin
          rsp_vld_d    = 1'b1;
          rsp_addr_d   = res_addr_q;
          rsp_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ffra_pkg::S_IDLE;
      rsp_vld_q    <= 1'b0;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      used_valid_q <= '0;
      hole_valid_q <= '0;
      changed_q    <= 1'b0;
      first_q      <= 1'b0;
      empty_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      rsp_vld_q    <= rsp_vld_d;
      cnt_q        <= cnt_d;
      rd_vld_q     <= rd_vld_d;
      used_valid_q <= used_valid_d;
      hole_valid_q <= hole_valid_d;
      changed_q    <= changed_d;
      first_q      <= first_d;
      empty_q      <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    rsp_status_q <= rsp_status_d;
    rsp_addr_q   <= rsp_addr_d;
    rd_idx_q     <= rd_idx_d;
    slot_q       <= slot_d;
    addr_q       <= addr_d;
    want_q       <= want_d;
    hstart_q     <= hstart_d;
    hlen_q       <= hlen_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
  end

  `FFRA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req.valid && req.ready, state_q != ffra_pkg::S_IDLE)
  `FFRA_ASSERT(a_fail_no_addr, clk_i, rst_ni, rsp.valid && (rsp.status != ffra_pkg::STAT_OK) |-> rsp.granted_address == '0)
  `FFRA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= ffra_pkg::SLOTS_CNT)
  `FFRA_ASSERT_NEXT(a_commit_marks_used, clk_i, rst_ni, state_q == ffra_pkg::S_A_COMMIT, used_valid_q[slot_q])

endmodule
